/* rtl/xorshift128_range_generator_top_assert.svh */
// assertion macros used by the checker file
`ifndef XORSHIFT128_RANGE_GENERATOR_TOP_ASSERT_SVH
`define XORSHIFT128_RANGE_GENERATOR_TOP_ASSERT_SVH

// plain check on the clock, always active
`define XRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check that is masked while reset is high
`define XRG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/xrg_pkg.sv */
`default_nettype none
package xrg_pkg;

  localparam logic [31:0] INIT_X        = 32'd123456789;
  localparam logic [31:0] INIT_Y        = 32'd362436069;
  localparam logic [31:0] INIT_Z        = 32'd521288629;
  localparam logic [31:0] INIT_W        = 32'd0;
  localparam logic [31:0] FALLBACK_SEED = 32'd88675123;
  localparam logic [31:0] LOW31_MASK    = 32'h7fffffff;
  localparam logic [31:0] FRAC23_MASK   = 32'h007fffff;

  localparam int SH_A = 11;
  localparam int SH_B = 19;
  localparam int SH_C = 8;

  // one remainder step per bit of the 31-bit dividend
  localparam int DIV_STEPS = 31;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_SEED  = 3'd0;
  localparam logic [2:0] CMD_RAW   = 3'd1;
  localparam logic [2:0] CMD_BELOW = 3'd2;
  localparam logic [2:0] CMD_RANGE = 3'd3;
  localparam logic [2:0] CMD_FRAC  = 3'd4;

  typedef enum logic [2:0] {
    OP_SEED,
    OP_RAW,
    OP_MOD,
    OP_FRAC,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] arg;     // seed word or raw divisor
    logic [31:0] addend;  // lower end for range requests
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } xs_state_t;

  function automatic xs_state_t xs_advance(input xs_state_t s);
    logic [31:0] t;
    xs_state_t   n;
    t   = s.x ^ (s.x << SH_A);
    n.x = s.y;
    n.y = s.z;
    n.z = s.w;
    n.w = (s.w ^ (s.w >> SH_B)) ^ (t ^ (t >> SH_C));
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/xrg_front.sv */
`default_nettype none
module xrg_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] seed_value,
  input  logic signed [31:0] bound_lo,
  input  logic signed [31:0] bound_hi,
  input  logic               q_full,
  output logic               push,
  output xrg_pkg::entry_t    entry
);
  import xrg_pkg::*;

  logic [31:0] span;
  logic [31:0] seed_u;
  logic        known;

  assign in_ready = !q_full;
  assign span     = bound_hi - bound_lo;
  assign seed_u   = seed_value;

  always_comb begin
    entry.op     = OP_ZERO;
    entry.arg    = '0;
    entry.addend = '0;
    known        = 1'b1;
    case (cmd)
      CMD_SEED: begin
        entry.op  = OP_SEED;
        entry.arg = (seed_u == '0 || seed_u[31]) ? FALLBACK_SEED : seed_u;
      end
      CMD_RAW: begin
        entry.op = OP_RAW;
      end
      CMD_BELOW: begin
        entry.op  = (bound_lo == '0) ? OP_ZERO : OP_MOD;
        entry.arg = bound_lo;
      end
      CMD_RANGE: begin
        entry.op     = (span == '0) ? OP_ZERO : OP_MOD;
        entry.arg    = span;
        entry.addend = (span == '0) ? '0 : bound_lo;
      end
      CMD_FRAC: begin
        entry.op = OP_FRAC;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused codes are taken and dropped
  assign push = in_valid && in_ready && known;

endmodule
`default_nettype wire

/* rtl/xrg_queue.sv */
`default_nettype none
module xrg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  xrg_pkg::entry_t  push_entry,
  input  logic             pop,
  output logic             full,
  output xrg_pkg::q_head_t head
);
  import xrg_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* rtl/xrg_back.sv */
`default_nettype none
module xrg_back (
  input  logic               clk,
  input  logic               rst,
  input  xrg_pkg::q_head_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);
  import xrg_pkg::*;

  state_t           state;
  state_t           state_next;
  xs_state_t        gen;
  xs_state_t        adv;
  logic [31:0]      rem;
  logic [31:0]      divisor;
  logic [30:0]      dq;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      addend;
  logic [31:0]      mag;
  logic [31:0]      shifted;
  logic             take;
  logic             load_out;

  assign adv     = xs_advance(gen);
  assign mag     = head.entry.arg[31] ? (32'd0 - head.entry.arg) : head.entry.arg;
  assign shifted = {rem[30:0], dq[30]};

  always_comb begin
    state_next = state;
    take       = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          take = 1'b1;
          case (head.entry.op)
            OP_SEED: state_next = S_IDLE;
            OP_MOD:  state_next = S_DIV;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen       <= '{x: INIT_X, y: INIT_Y, z: INIT_Z, w: INIT_W};
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        case (head.entry.op)
          OP_SEED: gen.w <= head.entry.arg;
          OP_ZERO: gen   <= gen;
          default: gen   <= adv;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cnt     <= '0;
      divisor <= mag;
      dq      <= adv.w[30:0];
      addend  <= head.entry.addend;
      case (head.entry.op)
        OP_RAW:  rem <= adv.w;
        OP_FRAC: rem <= adv.w & FRAC23_MASK;
        default: rem <= '0;
      endcase
    end else if (state == S_DIV) begin
      cnt <= cnt + 1'b1;
      dq  <= {dq[29:0], 1'b0};
      rem <= (shifted >= divisor) ? (shifted - divisor) : shifted;
    end
    if (load_out) begin
      value <= rem + addend;
    end
  end

endmodule
`default_nettype wire

/* rtl/xorshift128_range_generator_top.sv */
// xorshift128 range generator
// input channel: in_valid / in_ready with cmd, seed_value, bound_lo, bound_hi;
//   a request is taken on a clock edge where in_valid and in_ready are high
// output channel: out_valid / out_ready with value, held until taken
// cmd 0 reseeds the last state word and produces nothing; cmds 1, 2, 3, 4
//   each produce one value; codes 5 to 7 are taken and dropped
// a front stage classifies each request into a two-entry queue, the back
//   stage owns the generator state and a bit-serial remainder unit
// a raw, fraction or zero-divisor request passes from the queue to S_FIN
//   and then to the output register; bound and range requests pass
//   through S_DIV for the 31 remainder steps, one dividend bit per cycle
// the back end takes the next request only once the previous result is
//   in the output register; a reseed returns it straight to S_IDLE
// reset (rst, synchronous) restores the default state words, empties the
//   queue and drops any pending output
// if the receiver stalls, the finished value waits in the output register,
//   the back end holds the next result, and the queue keeps taking requests
//   until it is full, after which in_ready drops
`default_nettype none
module xorshift128_range_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] seed_value,
  input  logic signed [31:0] bound_lo,
  input  logic signed [31:0] bound_hi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);
  import xrg_pkg::*;

  // request path between the stages
  logic    push;
  entry_t  push_entry;
  logic    q_full;
  logic    pop;
  q_head_t head;

  // front: decode the command and precompute the divisor
  xrg_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .seed_value (seed_value),
    .bound_lo   (bound_lo),
    .bound_hi   (bound_hi),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  // short queue decouples acceptance from execution
  xrg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head       (head)
  );

  // back: generator state, remainder unit and output register
  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

endmodule
`default_nettype wire

/* rtl/xrg_checker.sv */
`default_nettype none
`include "xorshift128_range_generator_top_assert.svh"
module xrg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [2:0]         cmd,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] value
);

  // a stalled result stays offered and unchanged
  `XRG_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(value), "output changed while stalled")

  // reset drops any pending result
  `XRG_ASSERT(a_rst_clears_out, rst |=> !out_valid, "output valid right after reset")

  // the queue is empty after reset, so requests are taken
  `XRG_ASSERT(a_rst_ready, rst |=> in_ready, "not ready right after reset")

  // a request that is not taken stays offered with the same command
  `XRG_ASSERT_RST(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(cmd), "request dropped while stalled")

endmodule

bind xorshift128_range_generator_top xrg_checker u_xrg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value)
);
`default_nettype wire
